### rtl/sem_pkg.sv
// ----------------------------------------------------------------------------
// sem_pkg: shared constants, types and functions
// Sizes, register indexes and the square-root step of the RGB Sobel block.
// ----------------------------------------------------------------------------
package sem_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int CFG_W_W    = 12;
	localparam int CFG_H_W    = 16;
	localparam int WEXT_W     = (CFG_W_W > COL_W + 1) ? CFG_W_W : COL_W + 1;
	localparam int ROW_W      = CFG_H_W + 1;

	localparam int CH_W       = 8;
	localparam int NUM_CH     = 3;
	localparam int PIX_W      = CH_W * NUM_CH;
	localparam int WIN_N      = 9;

	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);
	localparam logic [CFG_W_W-1:0]   WIDTH_RESET      = CFG_W_W'(640);
	localparam logic [CFG_H_W-1:0]   HEIGHT_RESET     = CFG_H_W'(480);

	localparam logic ACTION_FLUSH = 1'b1;

	localparam int G_W         = 11;
	localparam int SUM_W       = 2 * G_W - 1;
	localparam int ROOT_IN_W   = 16;
	localparam int MAG_W       = 8;
	localparam int ROOT_STAGES = 4;
	localparam int ROOT_BPS    = MAG_W / ROOT_STAGES;
	localparam int MAG_LAT     = ROOT_STAGES + 3;

	localparam logic [SUM_W-1:0] SAT_LIMIT = SUM_W'(65280);

	typedef struct packed {
		logic [ROOT_IN_W-1:0] rem;
		logic [MAG_W-1:0]     n;
	} root_t;

	typedef struct packed {
		logic col_zero;
		logic out;
		logic top_zero;
		logic bot_zero;
		logic last;
	} s1_ctl_t;

	// one restoring square-root digit: try bit k of the root
	function automatic root_t root_bit(root_t cur, int k);
		logic [ROOT_IN_W:0] d;
		root_t              nxt;
		d   = ((ROOT_IN_W + 1)'(cur.n) << (k + 1)) + ((ROOT_IN_W + 1)'(1) << (2 * k));
		nxt = cur;
		if (d <= {1'b0, cur.rem}) begin
			nxt.rem = cur.rem - d[ROOT_IN_W-1:0];
			nxt.n   = cur.n | (MAG_W'(1) << k);
		end
		return nxt;
	endfunction

endpackage

### rtl/sem_if.sv
// ----------------------------------------------------------------------------
// sem_if: stream and configuration channels
// Pixel input, result output and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface sem_pix_if;
	import sem_pkg::*;
	logic            valid;
	logic            ready;
	logic            action;
	logic [CH_W-1:0] in_red;
	logic [CH_W-1:0] in_green;
	logic [CH_W-1:0] in_blue;
	modport source (output valid, action, in_red, in_green, in_blue, input ready);
	modport sink   (input valid, action, in_red, in_green, in_blue, output ready);
endinterface

interface sem_res_if;
	import sem_pkg::*;
	logic             valid;
	logic             ready;
	logic [MAG_W-1:0] out_red;
	logic [MAG_W-1:0] out_green;
	logic [MAG_W-1:0] out_blue;
	logic             frame_end;
	modport source (output valid, out_red, out_green, out_blue, frame_end, input ready);
	modport sink   (input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface

interface sem_cfg_if;
	import sem_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### rtl/sem_ram.sv
// ----------------------------------------------------------------------------
// sem_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module sem_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/sem_mag.sv
// ----------------------------------------------------------------------------
// sem_mag: Sobel gradient magnitude of one channel
// Gradients, sum of squares, pipelined rounded root with clamp to 255.
// ----------------------------------------------------------------------------
module sem_mag (
	input  logic                      clk,
	input  logic                      en,
	input  logic [sem_pkg::CH_W-1:0]  px [sem_pkg::WIN_N],
	output logic [sem_pkg::MAG_W-1:0] mag
);
	import sem_pkg::*;

	logic signed [G_W-1:0]   e [WIN_N];
	logic signed [G_W-1:0]   gx, gy;
	logic signed [G_W-1:0]   gx_s1, gy_s1;
	logic signed [2*G_W-1:0] sqx, sqy;
	logic [SUM_W-1:0]        sum;
	root_t                   rt_q  [ROOT_STAGES+1];
	root_t                   step  [ROOT_STAGES];
	logic                    sat_q [ROOT_STAGES+1];

	always_comb begin
		for (int k = 0; k < WIN_N; k++) begin
			e[k] = G_W'(px[k]);
		end
		// window index is col*3 + row
		gx = e[6] - e[0] + ((e[7] - e[1]) <<< 1) + e[8] - e[2];
		gy = e[2] - e[0] + ((e[5] - e[3]) <<< 1) + e[8] - e[6];
	end

	always_comb begin
		sqx = gx_s1 * gx_s1;
		sqy = gy_s1 * gy_s1;
		sum = sqx[SUM_W-1:0] + sqy[SUM_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			gx_s1    <= gx;
			gy_s1    <= gy;
			rt_q[0]  <= '{rem: sum[ROOT_IN_W-1:0], n: '0};
			sat_q[0] <= sum > SAT_LIMIT;
		end
	end

	for (genvar j = 0; j < ROOT_STAGES; j++) begin : g_root
		always_comb begin : p_step
			root_t cur;
			cur = rt_q[j];
			for (int b = 0; b < ROOT_BPS; b++) begin
				cur = root_bit(cur, MAG_W - 1 - j * ROOT_BPS - b);
			end
			step[j] = cur;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_q[j+1]  <= step[j];
				sat_q[j+1] <= sat_q[j];
			end
		end
	end

	// round up when the remainder exceeds the root
	always_ff @(posedge clk) begin
		if (en) begin
			if (sat_q[ROOT_STAGES]) begin
				mag <= '1;
			end else begin
				mag <= rt_q[ROOT_STAGES].n
					+ MAG_W'(rt_q[ROOT_STAGES].rem > ROOT_IN_W'(rt_q[ROOT_STAGES].n));
			end
		end
	end

endmodule

### rtl/sobel_edge_magnitude_rgb.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb: streaming 3x3 Sobel magnitude on RGB pixels
// Throughput one transfer per cycle; the whole pipe holds while a result waits.
// A result is valid once the transfer that completes its window has passed stage 1,
// stage 2 and the magnitude pipes; the stream lags the input by one line plus one pixel.
// Line stores are one 48-bit RAM read and written back per pixel.
// Reset: size registers to 640x480, position counters to zero, RAM not cleared.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_rgb (
	input logic     clk,
	input logic     arst_n,
	sem_pix_if.sink   pixels,
	sem_res_if.source results,
	sem_cfg_if.sink   cfg
);
	import sem_pkg::*;

	logic [CFG_W_W-1:0] width_q;
	logic [CFG_H_W-1:0] height_q;
	logic [WEXT_W-1:0]  w_eff;
	logic [CFG_H_W-1:0] h_eff;
	logic [ROW_W-1:0]   h_ext, h_m1;
	logic               cfg_wr_w, cfg_wr_h;

	logic [COL_W-1:0]   c_q;
	logic [ROW_W-1:0]   r_q;
	logic [WEXT_W-1:0]  c_inc;
	logic [ROW_W-1:0]   r_m1, r_m2, orow;
	logic               en, frame_done, take;
	s1_ctl_t            ctl;
	logic [PIX_W-1:0]   pix;

	logic               v_s1, fwd_q;
	s1_ctl_t            ctl_s1;
	logic [PIX_W-1:0]   pix_s1;
	logic [COL_W-1:0]   addr_s1;
	logic [2*PIX_W-1:0] wr_q, wr_data, rd_data;
	logic [PIX_W-1:0]   upper, middle;
	logic [PIX_W-1:0]   window_q   [WIN_N];
	logic [PIX_W-1:0]   win_cur    [WIN_N];
	logic [PIX_W-1:0]   window_nx  [WIN_N];
	logic [PIX_W-1:0]   win_msk    [WIN_N];

	logic               v_s2, last_s2;
	logic [PIX_W-1:0]   win_s2     [WIN_N];
	logic               vpipe_q    [MAG_LAT];
	logic               lpipe_q    [MAG_LAT];
	logic [CH_W-1:0]    ch_px      [NUM_CH][WIN_N];
	logic [MAG_W-1:0]   mag        [NUM_CH];

	// configuration
	assign cfg.ready = 1'b1;
	assign cfg_wr_w  = cfg.valid && cfg.ready && (cfg.index == REG_IMAGE_WIDTH);
	assign cfg_wr_h  = cfg.valid && cfg.ready && (cfg.index == REG_IMAGE_HEIGHT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else begin
			if (cfg_wr_w) begin
				width_q <= cfg.data[CFG_W_W-1:0];
			end
			if (cfg_wr_h) begin
				height_q <= cfg.data[CFG_H_W-1:0];
			end
		end
	end

	always_comb begin
		if (width_q == '0) begin
			w_eff = WEXT_W'(1);
		end else if (WEXT_W'(width_q) > WEXT_W'(MAX_WIDTH)) begin
			w_eff = WEXT_W'(MAX_WIDTH);
		end else begin
			w_eff = WEXT_W'(width_q);
		end
		h_eff = (height_q == '0) ? CFG_H_W'(1) : height_q;
		h_ext = ROW_W'(h_eff);
		h_m1  = h_ext - ROW_W'(1);
	end

	// input side: position and output decision
	assign en           = !results.valid || results.ready;
	assign pixels.ready = en;

	always_comb begin
		frame_done   = r_q >= h_ext;
		take         = pixels.valid && en
			&& !(pixels.action == ACTION_FLUSH && !frame_done);
		r_m1         = r_q - ROW_W'(1);
		r_m2         = r_q - ROW_W'(2);
		ctl.col_zero = c_q == '0;
		if (ctl.col_zero) begin
			ctl.out = (r_q >= ROW_W'(2)) && (r_m2 < h_ext);
			orow    = r_m2;
		end else begin
			ctl.out = (r_q != '0) && (r_m1 < h_ext);
			orow    = r_m1;
		end
		ctl.top_zero = orow == '0;
		ctl.bot_zero = orow == h_m1;
		ctl.last     = ctl.out && ctl.col_zero && ctl.bot_zero;
		c_inc        = WEXT_W'(c_q) + WEXT_W'(1);
		pix          = frame_done ? '0 : {pixels.in_red, pixels.in_green, pixels.in_blue};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q <= '0;
			r_q <= '0;
		end else if (cfg_wr_w || cfg_wr_h) begin
			c_q <= '0;
			r_q <= '0;
		end else if (take) begin
			if (ctl.last) begin
				c_q <= '0;
				r_q <= '0;
			end else if (c_inc >= w_eff) begin
				c_q <= '0;
				r_q <= r_q + ROW_W'(1);
			end else begin
				c_q <= c_inc[COL_W-1:0];
			end
		end
	end

	// line stores: {upper, middle} per column
	sem_ram #(
		.WIDTH (2 * PIX_W),
		.DEPTH (MAX_WIDTH)
	) u_lines (
		.clk     (clk),
		.wr_en   (en && v_s1),
		.wr_addr (addr_s1),
		.wr_data (wr_data),
		.rd_en   (take),
		.rd_addr (c_q),
		.rd_data (rd_data)
	);

	// stage 1: read-modify-write and window shift
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			fwd_q <= 1'b0;
		end else if (en) begin
			v_s1  <= take;
			fwd_q <= take && v_s1 && (c_q == addr_s1);
		end
	end

	always_comb begin
		upper   = fwd_q ? wr_q[2*PIX_W-1:PIX_W] : rd_data[2*PIX_W-1:PIX_W];
		middle  = fwd_q ? wr_q[PIX_W-1:0]       : rd_data[PIX_W-1:0];
		wr_data = {middle, pix_s1};
		for (int k = 0; k < 6; k++) begin
			win_cur[k] = window_q[k+3];
		end
		if (ctl_s1.col_zero) begin
			win_cur[6] = '0;
			win_cur[7] = '0;
			win_cur[8] = '0;
			for (int k = 0; k < 6; k++) begin
				window_nx[k] = '0;
			end
			window_nx[6] = upper;
			window_nx[7] = middle;
			window_nx[8] = pix_s1;
		end else begin
			win_cur[6] = upper;
			win_cur[7] = middle;
			win_cur[8] = pix_s1;
			window_nx  = win_cur;
		end
		win_msk = win_cur;
		if (ctl_s1.top_zero) begin
			win_msk[0] = '0;
			win_msk[3] = '0;
			win_msk[6] = '0;
		end
		if (ctl_s1.bot_zero) begin
			win_msk[2] = '0;
			win_msk[5] = '0;
			win_msk[8] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (take) begin
				ctl_s1  <= ctl;
				pix_s1  <= pix;
				addr_s1 <= c_q;
			end
			if (v_s1) begin
				wr_q     <= wr_data;
				window_q <= window_nx;
				win_s2   <= win_msk;
				last_s2  <= ctl_s1.last;
			end
		end
	end

	// stage 2 onwards: valid and frame-end tracking beside the magnitude pipes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			for (int i = 0; i < MAG_LAT; i++) begin
				vpipe_q[i] <= 1'b0;
			end
		end else if (en) begin
			v_s2       <= v_s1 && ctl_s1.out;
			vpipe_q[0] <= v_s2;
			for (int i = 1; i < MAG_LAT; i++) begin
				vpipe_q[i] <= vpipe_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lpipe_q[0] <= last_s2;
			for (int i = 1; i < MAG_LAT; i++) begin
				lpipe_q[i] <= lpipe_q[i-1];
			end
		end
	end

	for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_ch
		always_comb begin
			for (int k = 0; k < WIN_N; k++) begin
				ch_px[ch][k] = win_s2[k][PIX_W-1-ch*CH_W -: CH_W];
			end
		end

		sem_mag u_mag (
			.clk (clk),
			.en  (en),
			.px  (ch_px[ch]),
			.mag (mag[ch])
		);
	end

	assign results.valid     = vpipe_q[MAG_LAT-1];
	assign results.frame_end = lpipe_q[MAG_LAT-1];
	assign results.out_red   = mag[0];
	assign results.out_green = mag[1];
	assign results.out_blue  = mag[2];

	a_fwd_live: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_q |-> v_s1)
		else $error("forwarded line data without a live stage-1 pixel");

	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		WEXT_W'(c_q) < w_eff)
		else $error("column counter beyond image width");

	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		r_q <= h_ext + ROW_W'(1))
		else $error("row counter beyond drain row");

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking bench for sobel_edge_magnitude_rgb
// Streams RGB frames of many sizes through the Sobel block under random idling
// and back-pressure, predicts every gradient result and checks them in order.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sem_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 600000;
	localparam int unsigned SETTLE_CYCLES = 32;
	localparam int unsigned HOLD_CYCLES   = 400;
	localparam int unsigned RANDOM_ITEMS  = 200;
	localparam logic        ACTION_PIXEL  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(15);

	typedef enum {IDLE_RX_HEAVY, IDLE_TX_HEAVY, IDLE_NONE} idle_mode_t;

	typedef struct packed {
		logic [MAG_W-1:0] red;
		logic [MAG_W-1:0] green;
		logic [MAG_W-1:0] blue;
		logic             frame_end;
	} magnitude_t;

	class sobel_scoreboard;
		typedef logic [PIX_W-1:0] window_t [3][3];

		logic [PIX_W-1:0]   upper_line [MAX_WIDTH];
		logic [PIX_W-1:0]   middle_line [MAX_WIDTH];
		window_t            win;
		int unsigned        col;
		int unsigned        row;
		logic [CFG_W_W-1:0] img_w;
		logic [CFG_H_W-1:0] img_h;
		magnitude_t         expected_magnitudes [$];
		int unsigned        errors;

		function new();
			foreach (upper_line[i]) begin
				upper_line[i]  = '0;
				middle_line[i] = '0;
			end
			img_w  = WIDTH_RESET;
			img_h  = HEIGHT_RESET;
			errors = 0;
			restart();
		endfunction

		function void restart();
			col = 0;
			row = 0;
			win = '{default: '0};
		endfunction

		function int unsigned frame_width();
			if (img_w == 0)
				return 1;
			if (img_w > MAX_WIDTH)
				return MAX_WIDTH;
			return img_w;
		endfunction

		function int unsigned frame_height();
			return (img_h == 0) ? 1 : img_h;
		endfunction

		function int unsigned outstanding();
			return expected_magnitudes.size();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			if (idx == REG_IMAGE_WIDTH) begin
				img_w = val[CFG_W_W-1:0];
				restart();
			end else if (idx == REG_IMAGE_HEIGHT) begin
				img_h = val[CFG_H_W-1:0];
				restart();
			end
		endfunction

		function logic [MAG_W-1:0] magnitude(window_t w3, int lsb);
			int          v [3][3];
			int          gx;
			int          gy;
			int unsigned s;
			int unsigned n;
			for (int c = 0; c < 3; c++)
				for (int r = 0; r < 3; r++)
					v[c][r] = int'((w3[c][r] >> lsb) & 'hFF);
			gx = -v[0][0] + v[2][0] - 2 * v[0][1] + 2 * v[2][1] - v[0][2] + v[2][2];
			gy = -v[0][0] - 2 * v[1][0] - v[2][0] + v[0][2] + 2 * v[1][2] + v[2][2];
			s  = gx * gx + gy * gy;
			if (s > 65280)
				return '1;
			n = 0;
			for (int b = MAG_W - 1; b >= 0; b--)
				if ((n | (1 << b)) * (n | (1 << b)) <= s)
					n = n | (1 << b);
			if (s > n * n + n)
				n++;
			return MAG_W'(n);
		endfunction

		// returns 0 when the item is ignored (flush before the frame is complete)
		function bit predict_pixel(logic act, logic [PIX_W-1:0] px_in);
			int unsigned      w;
			int unsigned      h;
			int unsigned      slot;
			int unsigned      orow;
			int unsigned      ocol;
			logic [PIX_W-1:0] top;
			logic [PIX_W-1:0] mid;
			logic [PIX_W-1:0] px;
			window_t          nw;
			bit               produces;
			magnitude_t       want;
			w = frame_width();
			h = frame_height();
			if (act == ACTION_FLUSH && row < h)
				return 0;
			px   = (row >= h) ? '0 : px_in;
			slot = (col < MAX_WIDTH) ? col : 0;
			top  = upper_line[slot];
			mid  = middle_line[slot];
			upper_line[slot]  = mid;
			middle_line[slot] = px;

			nw[0]    = win[1];
			nw[1]    = win[2];
			produces = 0;
			orow     = 0;
			ocol     = 0;
			if (col >= 1) begin
				nw[2] = '{top, mid, px};
				if (row >= 1) begin
					produces = 1;
					orow     = row - 1;
					ocol     = col - 1;
				end
				win = nw;
			end else begin
				nw[2] = '{default: '0};
				if (row >= 2) begin
					produces = 1;
					orow     = row - 2;
					ocol     = w - 1;
				end
				win    = '{default: '0};
				win[2] = '{top, mid, px};
			end

			col++;
			if (col >= w) begin
				col = 0;
				row++;
			end

			if (!produces || orow >= h)
				return 1;
			// rows outside the image read as zero
			if (orow == 0)
				for (int c = 0; c < 3; c++)
					nw[c][0] = '0;
			if (orow == h - 1)
				for (int c = 0; c < 3; c++)
					nw[c][2] = '0;
			want.red       = magnitude(nw, 16);
			want.green     = magnitude(nw, 8);
			want.blue      = magnitude(nw, 0);
			want.frame_end = (orow == h - 1) && (ocol == w - 1);
			expected_magnitudes.push_back(want);
			if (want.frame_end)
				restart();
			return 1;
		endfunction

		function void check_magnitudes(magnitude_t got);
			magnitude_t want;
			if (expected_magnitudes.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: r=%0d g=%0d b=%0d end=%0b",
						got.red, got.green, got.blue, got.frame_end);
				return;
			end
			want = expected_magnitudes.pop_front();
			if (got.red !== want.red || got.green !== want.green ||
			    got.blue !== want.blue || got.frame_end !== want.frame_end) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected r=%0d g=%0d b=%0d end=%0b, got r=%0d g=%0d b=%0d end=%0b",
						want.red, want.green, want.blue, want.frame_end,
						got.red, got.green, got.blue, got.frame_end);
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        hold_req = 1'b0;
	int unsigned cycle_count = 0;
	int unsigned consumed = 0;
	idle_mode_t  idle_mode = IDLE_RX_HEAVY;
	sobel_scoreboard board = new();

	sem_pix_if pix_ch ();
	sem_res_if res_ch ();
	sem_cfg_if cfg_ch ();

	sobel_edge_magnitude_rgb dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixels  (pix_ch),
		.results (res_ch),
		.cfg     (cfg_ch)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("status: fail");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			board.check_magnitudes({res_ch.out_red, res_ch.out_green, res_ch.out_blue,
				res_ch.frame_end});
	end

	function automatic bit sender_waits();
		case (idle_mode)
			IDLE_RX_HEAVY: return $urandom_range(99) < 11;
			IDLE_TX_HEAVY: return $urandom_range(99) < 55;
			default:       return 0;
		endcase
	endfunction

	function automatic bit receiver_ready();
		case (idle_mode)
			IDLE_RX_HEAVY: return $urandom_range(99) >= 55;
			IDLE_TX_HEAVY: return $urandom_range(99) >= 11;
			default:       return 1;
		endcase
	endfunction

	// result side: random ready, with one long hold-off on request
	initial begin
		bit held;
		held = 1'b0;
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (hold_req && !held) begin
				held = 1'b1;
				res_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			res_ch.ready <= receiver_ready();
		end
	end

	function automatic logic [PIX_W-1:0] random_pixel();
		logic [PIX_W-1:0] px;
		for (int ch = 0; ch < NUM_CH; ch++)
			case ($urandom_range(3))
				0:       px[ch*CH_W +: CH_W] = '0;
				1:       px[ch*CH_W +: CH_W] = '1;
				default: px[ch*CH_W +: CH_W] = CH_W'($urandom);
			endcase
		return px;
	endfunction

	task automatic offer(input logic act, input logic [PIX_W-1:0] px);
		if (sender_waits()) begin
			pix_ch.valid <= 1'b0;
			@(posedge clk);
			while (sender_waits())
				@(posedge clk);
		end
		pix_ch.valid    <= 1'b1;
		pix_ch.action   <= act;
		pix_ch.in_red   <= px[23:16];
		pix_ch.in_green <= px[15:8];
		pix_ch.in_blue  <= px[7:0];
		do @(posedge clk); while (!pix_ch.ready);
		if (board.predict_pixel(act, px))
			consumed++;
	endtask

	task automatic drain_results();
		pix_ch.valid <= 1'b0;
		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		do @(posedge clk); while (!cfg_ch.ready);
		board.write_reg(idx, val);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_frame(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
		drain_results();
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
	endtask

	// W + 1 drain steps, mixing flush ticks and surplus data pixels
	task automatic send_tail();
		int unsigned n;
		n = board.frame_width() + 1;
		for (int unsigned i = 0; i < n; i++)
			offer(($urandom_range(99) < 70) ? ACTION_FLUSH : ACTION_PIXEL, random_pixel());
	endtask

	task automatic random_frame(inout bit restart_due);
		int unsigned w;
		int unsigned h;
		int unsigned total;
		int unsigned cut;
		int unsigned pause_at;
		if (restart_due || $urandom_range(99) < 70) begin
			case ($urandom_range(9))
				0, 1:    w = $urandom_range(40, 7);
				2:       w = 0;
				default: w = $urandom_range(6, 1);
			endcase
			case ($urandom_range(19))
				0:          h = 0;
				1, 2, 3, 4: h = $urandom_range(12, 6);
				default:    h = $urandom_range(5, 1);
			endcase
			set_frame({4'($urandom), 12'(w)}, 16'(h));
		end
		total    = board.frame_width() * board.frame_height();
		cut      = ($urandom_range(99) < 15) ? $urandom_range(total - 1, 0) : total;
		pause_at = ($urandom_range(99) < 20) ? $urandom_range(total - 1, 0) : total;
		for (int unsigned i = 0; i < cut; i++) begin
			if ($urandom_range(99) < 4)
				offer(ACTION_FLUSH, random_pixel());
			if (i == pause_at)
				drain_results();
			offer(ACTION_PIXEL, random_pixel());
		end
		restart_due = (cut != total);
		if (!restart_due)
			send_tail();
	endtask

	logic [PIX_W-1:0] corner_frame [12] = '{
		24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF,
		24'hFFFFFF, 24'hFFFFFF, 24'h0000FF, 24'hFF0000,
		24'h000000, 24'h00FF00, 24'hFFFFFF, 24'h000000
	};

	initial begin
		bit          restart_due;
		int unsigned start;
		arst_n          <= 1'b0;
		pix_ch.valid    <= 1'b0;
		pix_ch.action   <= ACTION_PIXEL;
		pix_ch.in_red   <= '0;
		pix_ch.in_green <= '0;
		pix_ch.in_blue  <= '0;
		cfg_ch.valid    <= 1'b0;
		cfg_ch.index    <= REG_IMAGE_WIDTH;
		cfg_ch.data     <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sizes straight out of reset, partial frame
		for (int i = 0; i < 20; i++)
			offer(ACTION_PIXEL, random_pixel());

		// 4x3 frame: upper data bits masked, early flush ignored,
		// unused register written mid-frame, surplus pixels act as flush
		set_frame(16'hA004, 16'd3);
		offer(ACTION_FLUSH, 24'hFFFFFF);
		for (int i = 0; i < 6; i++)
			offer(ACTION_PIXEL, corner_frame[i]);
		drain_results();
		write_reg(REG_UNUSED, 16'hFFFF);
		for (int i = 6; i < 12; i++)
			offer(ACTION_PIXEL, corner_frame[i]);
		offer(ACTION_PIXEL, 24'hFFFFFF);
		offer(ACTION_FLUSH, 24'h000000);
		offer(ACTION_PIXEL, 24'h5A5A5A);
		offer(ACTION_FLUSH, 24'hFFFFFF);
		offer(ACTION_FLUSH, 24'h000000);

		// zero sizes behave as 1x1
		set_frame(16'h0000, 16'h0000);
		offer(ACTION_FLUSH, 24'h000000);
		offer(ACTION_PIXEL, 24'hFFFFFF);
		offer(ACTION_FLUSH, 24'h000000);
		offer(ACTION_PIXEL, 24'hA5A5A5);

		// output held off so the input backs up
		set_frame(16'd8, 16'd6);
		hold_req <= 1'b1;
		for (int i = 0; i < 48; i++)
			offer(ACTION_PIXEL, random_pixel());
		send_tail();

		// tallest frame, abandoned part way
		set_frame(16'd1, 16'hFFFF);
		for (int i = 0; i < 40; i++)
			offer(ACTION_PIXEL, random_pixel());

		restart_due = 1;
		for (int m = IDLE_RX_HEAVY; m <= IDLE_NONE; m++) begin
			idle_mode = idle_mode_t'(m);
			start     = consumed;
			while (consumed - start < RANDOM_ITEMS)
				random_frame(restart_due);
		end

		pix_ch.valid <= 1'b0;
		while (board.outstanding() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.outstanding() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
